@@ hdl/dnrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dnrs_pkg
// Shared constants, codes and control structs of the directional neighbour
// rectangle search block.
// ----------------------------------------------------------------------------
`default_nettype none

package dnrs_pkg;

   // default sizes
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int COORD_BITS_DEF  = 16;

   // fixed field widths
   localparam int COMMAND_BITS = 2;
   localparam int DIR_BITS     = 2;
   localparam int INDEX_BITS   = 4;

   // command codes
   localparam logic [COMMAND_BITS-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_APPEND = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_QUERY  = 2'd2;

   // direction codes
   localparam logic [DIR_BITS-1:0] DIR_NORTH = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_EAST  = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_SOUTH = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_WEST  = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic clear;       // empty the table
      logic append;      // write the incoming rectangle
      logic load_query;  // latch the query rectangle and direction
      logic scan_start;  // rewind the scan and forget the best entry
      logic scan_step;   // read the next table entry
      logic shift;       // move the query past the far extreme
      logic load_rsp;    // capture the answer in the output register
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_end;    // every valid entry has been read
      logic hit;         // a candidate has been found in this pass
      logic count_zero;  // the table is empty
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hdl/dnrs_req_if.sv @@
// ----------------------------------------------------------------------------
// dnrs_req_if
// Request channel: command and query or append rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnrs_req_if #(
   parameter int COORD_BITS = dnrs_pkg::COORD_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [dnrs_pkg::COMMAND_BITS-1:0]   command;
   logic signed [COORD_BITS-1:0]        left_edge;
   logic signed [COORD_BITS-1:0]        top_edge;
   logic signed [COORD_BITS-1:0]        right_edge;
   logic signed [COORD_BITS-1:0]        bottom_edge;
   logic [dnrs_pkg::DIR_BITS-1:0]       direction;
   logic                                wrap_enable;

   modport source (
      output valid, command, left_edge, top_edge, right_edge, bottom_edge,
             direction, wrap_enable,
      input  ready
   );

   modport sink (
      input  valid, command, left_edge, top_edge, right_edge, bottom_edge,
             direction, wrap_enable,
      output ready
   );
endinterface

`default_nettype wire

@@ hdl/dnrs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dnrs_rsp_if
// Response channel: query answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnrs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [dnrs_pkg::INDEX_BITS-1:0]   entry_index;

   modport source (
      output valid, found, entry_index,
      input  ready
   );

   modport sink (
      input  valid, found, entry_index,
      output ready
   );
endinterface

`default_nettype wire

@@ hdl/directional_neighbor_rect_search.sv @@
// Clear and append are done at acceptance and leave the block ready for the next transaction.
// A query reads each stored entry once per pass (one table read per entry per pass),
// and runs a second pass when the wrap retry is taken.
// One transaction is in progress at a time; a finished answer waits in the output
// register while the next transaction is accepted.
// Reset empties the table; stored rectangles are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// directional_neighbor_rect_search
// Table of rectangles with a nearest-neighbour search in one of four
// directions, with optional wrap-around retry from the far side.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_neighbor_rect_search #(
   parameter int MAX_ENTRIES = dnrs_pkg::MAX_ENTRIES_DEF,
   parameter int COORD_BITS  = dnrs_pkg::COORD_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dnrs_req_if.sink    req_chan,
   dnrs_rsp_if.source  rsp_chan
);

   dnrs_pkg::ctl_cmd_type cmd;
   dnrs_pkg::dp_stat_type stat;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_found;
   logic [dnrs_pkg::INDEX_BITS-1:0] rsp_entry_index;

   // sequencer
   dnrs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_ready),
      .req_command     (req_chan.command),
      .req_wrap_enable (req_chan.wrap_enable),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_chan.ready),
      .cmd             (cmd),
      .stat            (stat)
   );

   // table and search datapath
   dnrs_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_left_edge   (req_chan.left_edge),
      .req_top_edge    (req_chan.top_edge),
      .req_right_edge  (req_chan.right_edge),
      .req_bottom_edge (req_chan.bottom_edge),
      .req_direction   (req_chan.direction),
      .rsp_found       (rsp_found),
      .rsp_entry_index (rsp_entry_index)
   );

   // channel hookup
   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.found       = rsp_found;
   assign rsp_chan.entry_index = rsp_entry_index;

endmodule

`default_nettype wire

@@ hdl/dnrs_datapath.sv @@
// ----------------------------------------------------------------------------
// dnrs_datapath
// Rectangle table, scan pipeline (read, measure, select), far-side extreme
// tracking, query shift and response payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnrs_datapath #(
   parameter int MAX_ENTRIES = dnrs_pkg::MAX_ENTRIES_DEF,
   parameter int COORD_BITS  = dnrs_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dnrs_pkg::ctl_cmd_type             cmd,
   output dnrs_pkg::dp_stat_type                  stat,
   input  wire logic signed [COORD_BITS-1:0]      req_left_edge,
   input  wire logic signed [COORD_BITS-1:0]      req_top_edge,
   input  wire logic signed [COORD_BITS-1:0]      req_right_edge,
   input  wire logic signed [COORD_BITS-1:0]      req_bottom_edge,
   input  wire logic [dnrs_pkg::DIR_BITS-1:0]     req_direction,
   output logic                                   rsp_found,
   output logic [dnrs_pkg::INDEX_BITS-1:0]        rsp_entry_index
);

   // query width covers the shifted query, metrics one bit more
   localparam int C  = COORD_BITS;
   localparam int QW = COORD_BITS + 3;
   localparam int DW = QW + 1;
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = IW + dnrs_pkg::INDEX_BITS;

   // table storage
   logic [4*C-1:0]               mem [MAX_ENTRIES];
   logic [CW-1:0]                count_ff, count_in;
   logic                         wr_en;

   // query state
   logic signed [QW-1:0]         ql_ff, qt_ff, qr_ff, qb_ff;
   logic signed [QW-1:0]         ql_in, qt_in, qr_in, qb_in;
   logic [dnrs_pkg::DIR_BITS-1:0] dir_ff;

   // scan pipeline
   logic [CW-1:0]                addr_ff;
   logic                         s1_valid_ff;
   logic [IW-1:0]                s1_idx_ff;
   logic [4*C-1:0]               s1_data_ff;
   logic                         s2_valid_ff;
   logic [IW-1:0]                s2_idx_ff;
   logic                         s2_cand_ff, s2_cand_in;
   logic [DW-1:0]                s2_gap_ff, s2_gap_in;
   logic signed [DW-1:0]         s2_ov_ff, s2_ov_in;
   logic signed [C-1:0]          s2_ext_ff, s2_ext_in;

   // selection state
   logic                         have_ff;
   logic [IW-1:0]                best_idx_ff;
   logic [DW-1:0]                best_gap_ff;
   logic signed [DW-1:0]         best_ov_ff;
   logic signed [C-1:0]          ext_ff;
   logic                         better;
   logic                         ext_lower;

   // metric working values
   logic signed [C-1:0]          r_l, r_t, r_r, r_b;
   logic signed [DW-1:0]         rl, rt, rr, rb, ql, qt, qr, qb;
   logic signed [DW-1:0]         hi_min, lo_max, diff;
   logic                         beyond;

   // shift working values
   logic signed [QW-1:0]         w, h, ext_q;

   // output payload
   logic                         found_ff;
   logic [dnrs_pkg::INDEX_BITS-1:0] idx_out_ff;
   logic [XW-1:0]                idx_wide;

   // table write and registered read
   assign wr_en = cmd.append && (count_ff < CW'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= {req_bottom_edge, req_right_edge,
                                   req_top_edge, req_left_edge};
      end
      if (cmd.scan_step) begin
         s1_data_ff <= mem[addr_ff[IW-1:0]];
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   // scan control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         addr_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= cmd.scan_step;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.scan_start) begin
            addr_ff <= '0;
            have_ff <= 1'b0;
         end else begin
            if (cmd.scan_step) begin
               addr_ff <= addr_ff + CW'(1);
            end
            if (s2_valid_ff && s2_cand_ff && better) begin
               have_ff <= 1'b1;
            end
         end
      end
   end

   // measure stage: cross-axis overlap, beyond test and edge gap
   always_comb begin
      r_l = s1_data_ff[C-1:0];
      r_t = s1_data_ff[2*C-1:C];
      r_r = s1_data_ff[3*C-1:2*C];
      r_b = s1_data_ff[4*C-1:3*C];
      rl  = DW'(r_l);
      rt  = DW'(r_t);
      rr  = DW'(r_r);
      rb  = DW'(r_b);
      ql  = DW'(ql_ff);
      qt  = DW'(qt_ff);
      qr  = DW'(qr_ff);
      qb  = DW'(qb_ff);
      if (dir_ff == dnrs_pkg::DIR_EAST || dir_ff == dnrs_pkg::DIR_WEST) begin
         hi_min = (qb < rb) ? qb : rb;
         lo_max = (qt > rt) ? qt : rt;
      end else begin
         hi_min = (qr < rr) ? qr : rr;
         lo_max = (ql > rl) ? ql : rl;
      end
      s2_ov_in = hi_min - lo_max;
      case (dir_ff)
         dnrs_pkg::DIR_NORTH: begin
            beyond    = rt < qt;
            diff      = rb - qt;
            s2_ext_in = r_b;
         end
         dnrs_pkg::DIR_EAST: begin
            beyond    = rr > qr;
            diff      = rl - qr;
            s2_ext_in = r_l;
         end
         dnrs_pkg::DIR_SOUTH: begin
            beyond    = rb > qb;
            diff      = rt - qb;
            s2_ext_in = r_t;
         end
         default: begin
            beyond    = rl < ql;
            diff      = rr - ql;
            s2_ext_in = r_r;
         end
      endcase
      s2_gap_in  = (diff < 0) ? DW'(-diff) : DW'(diff);
      s2_cand_in = (s2_ov_in > 0) && beyond;
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= addr_ff[IW-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_cand_ff <= s2_cand_in;
      s2_gap_ff  <= s2_gap_in;
      s2_ov_ff   <= s2_ov_in;
      s2_ext_ff  <= s2_ext_in;
   end

   // select stage: nearest gap, then widest overlap, then earliest entry
   assign better = !have_ff || (s2_gap_ff < best_gap_ff) ||
                   ((s2_gap_ff == best_gap_ff) && (s2_ov_ff > best_ov_ff));
   assign ext_lower = (dir_ff == dnrs_pkg::DIR_EAST) ||
                      (dir_ff == dnrs_pkg::DIR_SOUTH);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_cand_ff && better) begin
         best_gap_ff <= s2_gap_ff;
         best_ov_ff  <= s2_ov_ff;
         best_idx_ff <= s2_idx_ff;
      end
      // far-side extreme over all entries
      if (s2_valid_ff) begin
         if (s2_idx_ff == '0) begin
            ext_ff <= s2_ext_ff;
         end else if (ext_lower) begin
            if (s2_ext_ff < ext_ff) begin
               ext_ff <= s2_ext_ff;
            end
         end else if (s2_ext_ff > ext_ff) begin
            ext_ff <= s2_ext_ff;
         end
      end
   end

   // query load and far-side shift
   always_comb begin
      w     = qr_ff - ql_ff;
      h     = qb_ff - qt_ff;
      ext_q = QW'(ext_ff);
      ql_in = ql_ff;
      qt_in = qt_ff;
      qr_in = qr_ff;
      qb_in = qb_ff;
      if (cmd.load_query) begin
         ql_in = QW'(req_left_edge);
         qt_in = QW'(req_top_edge);
         qr_in = QW'(req_right_edge);
         qb_in = QW'(req_bottom_edge);
      end else if (cmd.shift) begin
         case (dir_ff)
            dnrs_pkg::DIR_NORTH: begin
               qt_in = ext_q + h;
               qb_in = ext_q + (h <<< 1);
            end
            dnrs_pkg::DIR_EAST: begin
               ql_in = ext_q - w;
               qr_in = ext_q;
            end
            dnrs_pkg::DIR_SOUTH: begin
               qt_in = ext_q - h;
               qb_in = ext_q;
            end
            default: begin
               ql_in = ext_q + w;
               qr_in = ext_q + (w <<< 1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ql_ff <= ql_in;
      qt_ff <= qt_in;
      qr_ff <= qr_in;
      qb_ff <= qb_in;
      if (cmd.load_query) begin
         dir_ff <= req_direction;
      end
   end

   // response payload register
   assign idx_wide = XW'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff   <= have_ff;
         idx_out_ff <= have_ff ? idx_wide[dnrs_pkg::INDEX_BITS-1:0] : '0;
      end
   end

   assign rsp_found       = found_ff;
   assign rsp_entry_index = idx_out_ff;

   // status
   assign stat.scan_end   = (addr_ff == count_ff);
   assign stat.hit        = have_ff;
   assign stat.count_zero = (count_ff == '0);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (CW'(s2_idx_ff) < count_ff))
      else $error("scan read an entry past the fill count");

   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (found_ff || idx_out_ff == '0))
      else $error("not-found answer carries a nonzero index");

endmodule

`default_nettype wire

@@ hdl/dnrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// dnrs_ctrl
// Sequencer: decodes commands, runs the scan passes, starts the wrap retry
// and hands the answer to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnrs_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dnrs_pkg::COMMAND_BITS-1:0]     req_command,
   input  wire logic                                  req_wrap_enable,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output dnrs_pkg::ctl_cmd_type                      cmd,
   input  wire dnrs_pkg::dp_stat_type                 stat
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      drain_ff, drain_in;
   logic      second_ff, second_in;
   logic      wrap_ff, wrap_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      second_in    = second_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  dnrs_pkg::CMD_CLEAR:  cmd.clear = 1'b1;
                  dnrs_pkg::CMD_APPEND: cmd.append = 1'b1;
                  dnrs_pkg::CMD_QUERY: begin
                     cmd.load_query = 1'b1;
                     cmd.scan_start = 1'b1;
                     wrap_in        = req_wrap_enable;
                     second_in      = 1'b0;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_end) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait for the measure and select stages to empty
            if (!drain_ff) begin
               drain_in = 1'b1;
            end else if (!second_ff && !stat.hit && wrap_ff && !stat.count_zero) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            cmd.shift      = 1'b1;
            cmd.scan_start = 1'b1;
            second_in      = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_RESP: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= 1'b0;
         second_ff    <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         second_ff    <= second_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_one_retry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && second_ff) |=> (state_ff != ST_SHIFT))
      else $error("wrap retry started twice for one query");

   a_shift_marks_second: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |=> (state_ff == ST_SCAN && second_ff))
      else $error("shift not followed by the second pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("answer loaded over an untaken response");

endmodule

`default_nettype wire

@@ tb/directional_neighbor_rect_search_tb.sv @@
// ----------------------------------------------------------------------------
// directional_neighbor_rect_search_tb
// Self-checking bench for the rectangle table and directional search. A
// queue of commands is streamed in bursts with random gaps, while the
// answer side stalls on a shifting pattern and once for a long stretch.
// Each accepted transaction updates a behavioural copy of the table, and
// every query answer is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_neighbor_rect_search_tb;

   localparam int MAX_ENTRIES   = dnrs_pkg::MAX_ENTRIES_DEF;
   localparam int COORD_BITS    = dnrs_pkg::COORD_BITS_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int ITEM_TARGET   = 650;
   localparam int PRINT_LIMIT   = 100;

   // command value the block does not decode
   localparam logic [dnrs_pkg::COMMAND_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [dnrs_pkg::COMMAND_BITS-1:0] command;
      coord_type                         left_edge;
      coord_type                         top_edge;
      coord_type                         right_edge;
      coord_type                         bottom_edge;
      logic [dnrs_pkg::DIR_BITS-1:0]     direction;
      logic                              wrap_enable;
      bit                                wait_idle;   // hold back until all answers are in
   } rect_cmd_type;

   // rectangle in wide arithmetic
   typedef struct packed {
      longint l;
      longint t;
      longint r;
      longint b;
   } box_type;

   typedef struct packed {
      logic                            found;
      logic [dnrs_pkg::INDEX_BITS-1:0] entry_index;
   } answer_type;

   logic clock;
   logic reset;

   dnrs_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   dnrs_rsp_if                            rsp_if ();

   directional_neighbor_rect_search #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COORD_BITS  (COORD_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow table and bookkeeping
   box_type      rect_tbl [MAX_ENTRIES];
   int           rect_fill;
   answer_type   expected_answers [$];
   rect_cmd_type pending [$];
   int           queries_sent;
   int           answers_seen;
   int           err_cnt;
   int           cycle_cnt;
   int           live_items;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      err_cnt++;
      if (err_cnt <= PRINT_LIMIT)
         $display("cycle %0d: mismatch: %s", cycle_cnt, what);
   endtask

   function automatic longint magnitude(input longint a);
      return (a < 0) ? -a : a;
   endfunction

   // one scan of the table: smallest gap, then widest overlap, then lowest slot
   function automatic bit nearest_in_pass(input box_type q,
                                          input logic [dnrs_pkg::DIR_BITS-1:0] dir,
                                          output int pos);
      bit      have;
      bit      beyond;
      longint  best_gap;
      longint  best_ov;
      longint  ov;
      longint  gap;
      box_type e;
      have     = 1'b0;
      best_gap = 0;
      best_ov  = 0;
      pos      = 0;
      for (int i = 0; i < rect_fill; i++) begin
         e = rect_tbl[i];
         if (dir == dnrs_pkg::DIR_EAST || dir == dnrs_pkg::DIR_WEST)
            ov = ((q.b < e.b) ? q.b : e.b) - ((q.t > e.t) ? q.t : e.t);
         else
            ov = ((q.r < e.r) ? q.r : e.r) - ((q.l > e.l) ? q.l : e.l);
         case (dir)
            dnrs_pkg::DIR_NORTH: begin
               beyond = e.t < q.t; gap = magnitude(e.b - q.t);
            end
            dnrs_pkg::DIR_EAST: begin
               beyond = e.r > q.r; gap = magnitude(e.l - q.r);
            end
            dnrs_pkg::DIR_SOUTH: begin
               beyond = e.b > q.b; gap = magnitude(e.t - q.b);
            end
            default: begin
               beyond = e.l < q.l; gap = magnitude(e.r - q.l);
            end
         endcase
         if (ov > 0 && beyond) begin
            if (!have || gap < best_gap || (gap == best_gap && ov > best_ov)) begin
               have     = 1'b1;
               best_gap = gap;
               best_ov  = ov;
               pos      = i;
            end
         end
      end
      return have;
   endfunction

   // place the query just outside the extreme entry on the far side
   function automatic box_type move_past_far_side(input box_type q,
                                                  input logic [dnrs_pkg::DIR_BITS-1:0] dir);
      longint  ext;
      longint  w;
      longint  h;
      longint  v;
      box_type m;
      m   = q;
      ext = 0;
      w   = q.r - q.l;
      h   = q.b - q.t;
      for (int i = 0; i < rect_fill; i++) begin
         case (dir)
            dnrs_pkg::DIR_NORTH: v = rect_tbl[i].b;
            dnrs_pkg::DIR_EAST:  v = rect_tbl[i].l;
            dnrs_pkg::DIR_SOUTH: v = rect_tbl[i].t;
            default:             v = rect_tbl[i].r;
         endcase
         if (i == 0)
            ext = v;
         else if (dir == dnrs_pkg::DIR_EAST || dir == dnrs_pkg::DIR_SOUTH)
            ext = (v < ext) ? v : ext;
         else
            ext = (v > ext) ? v : ext;
      end
      case (dir)
         dnrs_pkg::DIR_NORTH: begin m.t = ext + h; m.b = m.t + h; end
         dnrs_pkg::DIR_EAST:  begin m.l = ext - w; m.r = m.l + w; end
         dnrs_pkg::DIR_SOUTH: begin m.t = ext - h; m.b = m.t + h; end
         default:             begin m.l = ext + w; m.r = m.l + w; end
      endcase
      return m;
   endfunction

   // apply one accepted transaction to the shadow table
   task automatic apply_to_table(input rect_cmd_type c);
      box_type    q;
      int         pos;
      bit         hit;
      answer_type a;
      q.l = longint'(c.left_edge);
      q.t = longint'(c.top_edge);
      q.r = longint'(c.right_edge);
      q.b = longint'(c.bottom_edge);
      case (c.command)
         dnrs_pkg::CMD_CLEAR: rect_fill = 0;
         dnrs_pkg::CMD_APPEND: begin
            if (rect_fill < MAX_ENTRIES) begin
               rect_tbl[rect_fill] = q;
               rect_fill++;
            end
         end
         dnrs_pkg::CMD_QUERY: begin
            hit = nearest_in_pass(q, c.direction, pos);
            if (!hit && c.wrap_enable && rect_fill > 0)
               hit = nearest_in_pass(move_past_far_side(q, c.direction), c.direction, pos);
            a.found       = hit;
            a.entry_index = hit ? pos[dnrs_pkg::INDEX_BITS-1:0] : '0;
            expected_answers.push_back(a);
         end
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [dnrs_pkg::COMMAND_BITS-1:0] cmd,
                           input int l, input int t, input int r, input int b,
                           input logic [dnrs_pkg::DIR_BITS-1:0] dir,
                           input logic wrap, input bit wait_idle = 1'b0);
      rect_cmd_type c;
      c.command     = cmd;
      c.left_edge   = coord_type'(l);
      c.top_edge    = coord_type'(t);
      c.right_edge  = coord_type'(r);
      c.bottom_edge = coord_type'(b);
      c.direction   = dir;
      c.wrap_enable = wrap;
      c.wait_idle   = wait_idle;
      pending.push_back(c);
      if (cmd != CMD_UNUSED)
         live_items++;
   endtask

   // rectangle near a scene origin, now and then inside out
   task automatic scene_rect(input int bx, input int by, output int l, output int t,
                             output int r, output int b);
      l = bx + int'($urandom_range(0, 48));
      t = by + int'($urandom_range(0, 48));
      r = l + int'($urandom_range(0, 12));
      b = t + int'($urandom_range(0, 12));
      if ($urandom_range(0, 11) == 0)
         r = l - int'($urandom_range(1, 5));
      if ($urandom_range(0, 11) == 0)
         b = t - int'($urandom_range(1, 5));
   endtask

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // request driver: bursts with random gaps, optional drain before an item
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : drive_requests
      logic next_valid;
      int   sent_now;
      next_valid = req_if.valid;
      sent_now   = queries_sent;
      if (reset) begin
         next_valid = 1'b0;
         sent_now   = 0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         // transaction taken this edge
         if (req_if.valid && req_if.ready) begin
            if (pending[0].command == dnrs_pkg::CMD_QUERY)
               sent_now++;
            apply_to_table(pending[0]);
            void'(pending.pop_front());
            next_valid = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               case ($urandom_range(0, 3))
                  0: begin
                     burst_left = $urandom_range(30, 80);
                     gap_left   = 0;
                  end
                  1: begin
                     burst_left = $urandom_range(1, 4);
                     gap_left   = $urandom_range(10, 40);
                  end
                  default: begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 6);
                  end
               endcase
            end
         end
         // offer the next transaction
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0 &&
                         (!pending[0].wait_idle || sent_now == answers_seen)) begin
               next_valid          = 1'b1;
               req_if.command     <= pending[0].command;
               req_if.left_edge   <= pending[0].left_edge;
               req_if.top_edge    <= pending[0].top_edge;
               req_if.right_edge  <= pending[0].right_edge;
               req_if.bottom_edge <= pending[0].bottom_edge;
               req_if.direction   <= pending[0].direction;
               req_if.wrap_enable <= pending[0].wrap_enable;
            end
         end
      end
      req_if.valid <= next_valid;
      queries_sent <= sent_now;
   end

   // answer monitor and receiver back-pressure
   logic [15:0] stall_pattern;
   int          pattern_pos;
   int          hold_left;
   bit          hold_done;

   always @(posedge clock) begin : collect_answers
      answer_type want;
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         answers_seen  <= 0;
         stall_pattern  = 16'hffff;
         pattern_pos    = 0;
         hold_left      = 0;
         hold_done      = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
               report_mismatch("answer with no query outstanding");
            end else begin
               want = expected_answers.pop_front();
               if (rsp_if.found !== want.found)
                  report_mismatch($sformatf("found got %b want %b",
                                            rsp_if.found, want.found));
               if (rsp_if.entry_index !== want.entry_index)
                  report_mismatch($sformatf("entry_index got %0d want %0d",
                                            rsp_if.entry_index, want.entry_index));
            end
         end
         // one long hold once traffic is flowing, so the block backs up
         if (!hold_done && queries_sent >= 60) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0)
            hold_left--;
         pattern_pos = (pattern_pos + 1) % 16;
         if (pattern_pos == 0)
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff
                                                         : (16'($urandom) | 16'h0101);
         rsp_if.ready <= (hold_left == 0) && stall_pattern[pattern_pos];
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int l, t, r, b;
      int base_x, base_y;
      int n_app, n_qry;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = dnrs_pkg::CMD_CLEAR;
      req_if.left_edge   = '0;
      req_if.top_edge    = '0;
      req_if.right_edge  = '0;
      req_if.bottom_edge = '0;
      req_if.direction   = dnrs_pkg::DIR_NORTH;
      req_if.wrap_enable = 1'b0;
      rsp_if.ready       = 1'b0;
      err_cnt            = 0;
      cycle_cnt          = 0;
      live_items         = 0;
      rect_fill          = 0;
      queries_sent       = 0;
      answers_seen       = 0;

      // empty table, with and without wrap, and an undecoded command
      add_item(dnrs_pkg::CMD_QUERY, 0, 0, 10, 10, dnrs_pkg::DIR_NORTH, 1'b0, 1'b1);
      add_item(dnrs_pkg::CMD_QUERY, 0, 0, 10, 10, dnrs_pkg::DIR_SOUTH, 1'b1);
      add_item(CMD_UNUSED, -1, -1, -1, -1, dnrs_pkg::DIR_WEST, 1'b1);
      // extreme, plain, neighbouring and inside-out entries
      add_item(dnrs_pkg::CMD_APPEND, -32768, -32768, 32767, 32767,
               dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 0, 0, 10, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 20, 0, 30, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 40, 10, 35, 5, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 0, -20, 10, -5, dnrs_pkg::DIR_NORTH, 1'b0);
      // every direction
      add_item(dnrs_pkg::CMD_QUERY, 12, 0, 18, 10, dnrs_pkg::DIR_EAST, 1'b0);
      add_item(dnrs_pkg::CMD_QUERY, 12, 0, 18, 10, dnrs_pkg::DIR_WEST, 1'b0);
      add_item(dnrs_pkg::CMD_QUERY, 0, 0, 10, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_QUERY, 0, 0, 10, 10, dnrs_pkg::DIR_SOUTH, 1'b1);
      // fresh table with a duplicate entry for the tie-break
      add_item(dnrs_pkg::CMD_CLEAR, 0, 0, 0, 0, dnrs_pkg::DIR_NORTH, 1'b0, 1'b1);
      add_item(dnrs_pkg::CMD_APPEND, 0, 0, 10, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 20, 0, 30, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, 20, 0, 30, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      add_item(dnrs_pkg::CMD_APPEND, -10, 0, -2, 10, dnrs_pkg::DIR_NORTH, 1'b0);
      // nothing further east: miss without wrap, hit after wrapping
      add_item(dnrs_pkg::CMD_QUERY, 32, 0, 40, 10, dnrs_pkg::DIR_EAST, 1'b1);
      add_item(dnrs_pkg::CMD_QUERY, 32, 0, 40, 10, dnrs_pkg::DIR_EAST, 1'b0);
      add_item(dnrs_pkg::CMD_QUERY, 12, 0, 18, 10, dnrs_pkg::DIR_WEST, 1'b0);
      add_item(dnrs_pkg::CMD_QUERY, 12, 0, 18, 10, dnrs_pkg::DIR_EAST, 1'b0);
      // full-span query: the wrapped position leaves the coordinate range
      add_item(dnrs_pkg::CMD_QUERY, -32768, -32768, 32767, 32767,
               dnrs_pkg::DIR_NORTH, 1'b1);
      add_item(dnrs_pkg::CMD_QUERY, 32767, 32767, -32768, -32768,
               dnrs_pkg::DIR_WEST, 1'b1);

      // random scenes: fill a table around an origin, then query it
      while (live_items < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) != 0) begin
               base_x = int'($urandom_range(0, 60)) - 30;
               base_y = int'($urandom_range(0, 60)) - 30;
            end else begin
               base_x = int'($urandom_range(0, 64000)) - 32000;
               base_y = int'($urandom_range(0, 64000)) - 32000;
            end
            if ($urandom_range(0, 4) != 0)
               add_item(dnrs_pkg::CMD_CLEAR, 0, 0, 0, 0, dnrs_pkg::DIR_NORTH, 1'b0,
                        $urandom_range(0, 15) == 0);
            n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
            repeat (n_app) begin
               scene_rect(base_x, base_y, l, t, r, b);
               add_item(dnrs_pkg::CMD_APPEND, l, t, r, b, 2'($urandom), 1'($urandom));
            end
            n_qry = $urandom_range(2, 8);
            repeat (n_qry) begin
               scene_rect(base_x, base_y, l, t, r, b);
               add_item(dnrs_pkg::CMD_QUERY, l, t, r, b, 2'($urandom), 1'($urandom));
            end
         end else begin
            // noise over the whole coordinate range
            repeat ($urandom_range(1, 4))
               add_item(2'($urandom), any_coord(), any_coord(), any_coord(), any_coord(),
                        2'($urandom), 1'($urandom));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: all transactions taken and every answer back
      while (pending.size() != 0 || queries_sent != answers_seen)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_answers.size() != 0)
         report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));

      if (err_cnt == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
